### hw/rtl/fms_pkg.sv
// Package for the filtered mean and standard deviation block.
// Holds register addresses, measure codes, command and status structs.
package fms_pkg;
    localparam int ACC_W       = 32;
    localparam int SQ_W        = 48;
    localparam int CNT_W       = 16;
    localparam int ADDR_W      = 4;
    localparam int SAMPLE_BITS = 16;

    localparam logic [ADDR_W-1:0] ADDR_YEAR    = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_MONTH   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_MEASURE = 4'h8;

    localparam logic [1:0] MEAS_SPEED = 2'd0;
    localparam logic [1:0] MEAS_TEMP  = 2'd1;

    typedef struct packed {
        logic accumulate;
        logic clear;
        logic start_fin;
        logic sqrt_step;
        logic div_step;
        logic round;
        logic check;
    } t_cmd;

    typedef struct packed {
        logic zero_count;
        logic step_last;
        logic div_last;
    } t_status;
endpackage

### hw/rtl/fms_datapath.sv
// Datapath: accumulators, product stage, bit-serial square root and dividers.
// Depends on fms_pkg.
module fms_datapath #(
    parameter int COUNT_CAP   = 65535
) (
    input  logic                                   i_clk,
    input  fms_pkg::t_cmd                          i_cmd,
    input  logic signed [fms_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                   i_match,
    output fms_pkg::t_status                       o_status,
    output logic [15:0]                            o_mean,
    output logic [15:0]                            o_stdev,
    output logic [15:0]                            o_count,
    input  logic                                   i_rst_n
);
    import fms_pkg::*;

    localparam int NUM_W = 64;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(COUNT_CAP);

    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_sum;
    logic [SQ_W-1:0]  r_sq;
    logic [NUM_W-1:0] r_x, r_res, r_bit;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_t;
    logic [6:0]       r_k;
    logic [ACC_W:0]   r_dividend, r_rem, r_quot;
    logic [ACC_W:0]   r_divisor;
    logic [CNT_W-1:0] r_outcnt;
    logic             r_neg, r_phase;
    logic [ACC_W-1:0] r_mag;
    logic [15:0]      r_mean, r_stdev;

    logic [SAMPLE_BITS-1:0]   w_abs;
    logic [2*SAMPLE_BITS-1:0] w_sq;
    logic [NUM_W-1:0]         w_trial;
    logic [ACC_W:0]           w_rem_sh;

    assign w_abs   = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_sample) : i_sample;
    assign w_sq    = w_abs * w_abs;
    assign w_trial = r_res + r_bit;
    assign w_rem_sh = {r_rem[ACC_W-1:0], r_dividend[ACC_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_sq  <= '0;
        end else if (i_cmd.accumulate && i_match && r_cnt < CAP) begin
            r_cnt <= r_cnt + 1'b1;
            r_sum <= r_sum + ACC_W'(i_sample);
            r_sq  <= r_sq + SQ_W'(w_sq);
        end
        if (i_cmd.start_fin) begin
            r_neg   <= r_sum[ACC_W-1];
            r_mag   <= r_sum[ACC_W-1] ? -r_sum : r_sum;
            r_outcnt <= r_cnt;
            r_num   <= NUM_W'(r_cnt) * NUM_W'(r_sq);
            r_phase <= 1'b0;
            r_k     <= '0;
        end else if (i_cmd.sqrt_step) begin
            if (!r_phase) begin
                r_num   <= (r_num >= NUM_W'(r_mag) * NUM_W'(r_mag)) ?
                           r_num - NUM_W'(r_mag) * NUM_W'(r_mag) : '0;
                r_phase <= 1'b1;
                r_res   <= '0;
                r_bit   <= 64'h4000_0000_0000_0000;
                r_k     <= '0;
            end else begin
                r_k <= r_k + 1'b1;
                if (r_k == 7'd0) r_x <= r_num;
                if (r_k != 7'd0) begin
                    if ((r_k == 7'd1 ? r_num : r_x) >= w_trial) begin
                        r_x   <= (r_k == 7'd1 ? r_num : r_x) - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                        if (r_k == 7'd1) r_x <= r_num;
                    end
                    r_bit <= r_bit >> 2;
                end
                if (r_k == 7'd32) begin
                    r_dividend <= {r_mag, 1'b0} + (ACC_W+1)'(r_outcnt);
                    r_divisor  <= (ACC_W+1)'({r_outcnt, 1'b0});
                    r_rem <= '0;
                    r_quot <= '0;
                end
            end
        end else if (i_cmd.div_step) begin
            r_k <= r_k + 1'b1;
            if (r_k == 7'd66) begin
                r_mean     <= r_neg ? 16'(-r_quot[15:0]) : r_quot[15:0];
                r_dividend <= {1'b0, r_res[ACC_W-1:0]};
                r_divisor  <= (ACC_W+1)'(r_outcnt);
                r_rem  <= '0;
                r_quot <= '0;
            end else begin
                if (w_rem_sh >= r_divisor) begin
                    r_rem  <= w_rem_sh - r_divisor;
                    r_quot <= {r_quot[ACC_W-1:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_quot <= {r_quot[ACC_W-1:0], 1'b0};
                end
                r_dividend <= r_dividend << 1;
            end
        end else if (i_cmd.round) begin
            r_t <= NUM_W'({r_quot, 1'b1}) * NUM_W'(r_outcnt);
        end else if (i_cmd.check) begin
            if (r_t < 64'h1_0000_0000 &&
                (r_num << 2) >= NUM_W'(r_t[31:0]) * NUM_W'(r_t[31:0]))
                r_stdev <= r_quot[15:0] + 1'b1;
            else
                r_stdev <= r_quot[15:0];
        end
    end

    assign o_status.zero_count = (r_cnt == '0);
    assign o_status.step_last  = r_phase && r_k == 7'd32;
    assign o_status.div_last   = r_k == 7'd99;
    assign o_mean  = r_mean;
    assign o_stdev = r_stdev;
    assign o_count = r_outcnt;
endmodule

### hw/rtl/fms_ctrl.sv
// Controller state machine: sequences accumulation and the final calculation.
// Depends on fms_pkg.
module fms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last,
    output logic             o_stall,
    input  fms_pkg::t_status i_status,
    output fms_pkg::t_cmd    o_cmd,
    output logic             o_valid,
    output logic             o_no_data,
    input  logic             i_stall
);
    import fms_pkg::*;

    typedef enum logic [2:0] {
        S_RUN, S_START, S_SQRT, S_DIV, S_ROUND, S_CHECK, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, r_no_data;
    logic   w_acc;

    assign o_stall = (r_state != S_RUN) || (r_valid && i_last);
    assign w_acc   = i_valid && !o_stall;

    always_comb begin
        o_cmd = '0;
        o_cmd.accumulate = w_acc;
        n_state = r_state;
        case (r_state)
            S_RUN:   if (w_acc && i_last) n_state = S_START;
            S_START: begin
                if (i_status.zero_count) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.start_fin = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT:  begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.step_last) n_state = S_DIV;
            end
            S_DIV:   begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_ROUND;
            end
            S_ROUND: begin o_cmd.round = 1'b1; n_state = S_CHECK; end
            S_CHECK: begin o_cmd.check = 1'b1; n_state = S_OUT; end
            S_OUT:   begin o_cmd.clear = 1'b1; n_state = S_RUN; end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_valid   <= 1'b0;
            r_no_data <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT) r_valid <= 1'b1;
            else if (r_valid && !i_stall) r_valid <= 1'b0;
            if (r_state == S_START) r_no_data <= i_status.zero_count;
        end
    end

    assign o_valid   = r_valid;
    assign o_no_data = r_no_data;
endmodule

### hw/rtl/filtered_mean_and_stdev.sv
// Top level: filtered mean and standard deviation over weather records.
// Depends on fms_pkg, fms_ctrl and fms_datapath.
//
// Records enter on the input channel (valid/stall) at one per cycle while the
// block does not stall its input. A record whose year and month match the
// configured ones adds the selected measure to the count, sum and sum of
// squares; the count saturates at its capacity. On the record marked last
// the block stalls its input and computes the result in steps: latch,
// square root, mean division, setup, standard deviation division, rounding
// and check, and output. With no matching record it goes from the latch step
// straight to output, and the result is valid with no_data set.
// The result holds in its register while the receiver stalls; a new record
// is taken meanwhile and only a further last record waits for it.
// Configuration is through an APB-style port, writes apply immediately.
// Reset clears accumulators and sets the registers to year 0, month 1, speed.
module filtered_mean_and_stdev #(
    parameter longint MAX_RECORDS = 65535
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [fms_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [13:0]              i_rec_year,
    input  logic [3:0]               i_rec_month,
    input  logic signed [15:0]       i_speed,
    input  logic signed [15:0]       i_temperature,
    input  logic signed [15:0]       i_solar,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [15:0]       o_mean,
    output logic [15:0]              o_stdev,
    output logic [15:0]              o_sample_count,
    output logic                     o_no_data
);
    import fms_pkg::*;

    localparam int COUNT_CAP = (MAX_RECORDS < 65535) ? int'(MAX_RECORDS) : 65535;

    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [1:0]  r_meas;
    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_match, w_no_data;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic [15:0] w_mean, w_stdev, w_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= '0;
            r_month <= 4'd1;
            r_meas  <= MEAS_SPEED;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr)
                ADDR_YEAR:    r_year  <= pwdata[13:0];
                ADDR_MONTH:   r_month <= pwdata[3:0];
                ADDR_MEASURE: r_meas  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_YEAR:    prdata = {18'd0, r_year};
            ADDR_MONTH:   prdata = {28'd0, r_month};
            ADDR_MEASURE: prdata = {30'd0, r_meas};
            default:      prdata = '0;
        endcase
    end

    assign w_match = (i_rec_year == r_year) && (i_rec_month == r_month);
    always_comb begin
        case (r_meas)
            MEAS_SPEED: w_sample = SAMPLE_BITS'(i_speed);
            MEAS_TEMP:  w_sample = SAMPLE_BITS'(i_temperature);
            default:    w_sample = SAMPLE_BITS'(i_solar);
        endcase
    end

    fms_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_last(i_last),
        .o_stall(o_stall), .i_status(w_status), .o_cmd(w_cmd),
        .o_valid(o_valid), .o_no_data(w_no_data), .i_stall(i_stall)
    );

    fms_datapath #(.COUNT_CAP(COUNT_CAP)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_sample(w_sample), .i_match(w_match),
        .o_status(w_status), .o_mean(w_mean), .o_stdev(w_stdev),
        .o_count(w_count), .i_rst_n(i_rst_n)
    );

    assign o_no_data      = w_no_data;
    assign o_mean         = w_no_data ? 16'sd0 : w_mean;
    assign o_stdev        = w_no_data ? 16'd0 : w_stdev;
    assign o_sample_count = w_no_data ? 16'd0 : w_count;
endmodule
